// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the rep counter (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is held.
`define ORC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ORC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ORC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/orc_pkg.sv
// Package of the rep counter: types, codes and constants.
`default_nettype none

package orc_pkg;

    // Q1.14 orientation component and quaternion, index 0 = w, 1 = x, 2 = y, 3 = z
    localparam int COMP_W  = 16;
    localparam int TOL_W   = 15;
    localparam int COUNT_W = 16;

    typedef logic [COMP_W-1:0] t_comp;
    typedef t_comp [3:0]       t_quat;

    localparam t_comp Q_ONE = 16'h4000;
    localparam t_quat QUAT_IDENTITY = {16'h0000, 16'h0000, 16'h0000, Q_ONE};

    localparam logic [TOL_W-1:0]   TOL_RESET = 15'd4915;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_POSE   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        POSE_OTHER       = 2'd0,
        POSE_THUMB_PINKY = 2'd1,
        POSE_SPREAD      = 2'd2,
        POSE_UNUSED      = 2'd3
    } t_pose;

    localparam logic [1:0] PULSES_NONE = 2'd0;
    localparam logic [1:0] PULSES_ONE  = 2'd1;
    localparam logic [1:0] PULSES_TWO  = 2'd2;

    // One input item as held in the input register
    typedef struct packed {
        t_opcode opcode;
        t_quat   quat;
        t_pose   pose;
    } t_item;

    // One result item
    typedef struct packed {
        logic [COUNT_W-1:0] rep_count;
        logic               rep_done;
        logic [COUNT_W-1:0] reported_reps;
        logic               report_valid;
        logic [1:0]         vibrate_pulses;
        logic               in_set_flag;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/orc_in_if.sv
// Input channel: orientation samples and pose events.
`default_nettype none

interface orc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] quat_w;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    logic [1:0]  pose_code;

    modport source (output valid, opcode, quat_w, quat_x, quat_y, quat_z, pose_code,
                    input ready);
    modport sink   (input valid, opcode, quat_w, quat_x, quat_y, quat_z, pose_code,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/orc_out_if.sv
// Output channel: one result per input transaction.
`default_nettype none

interface orc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rep_count;
    logic        rep_done;
    logic [15:0] reported_reps;
    logic        report_valid;
    logic [1:0]  vibrate_pulses;
    logic        in_set_flag;

    modport source (output valid, rep_count, rep_done, reported_reps, report_valid,
                    vibrate_pulses, in_set_flag, input ready);
    modport sink   (input valid, rep_count, rep_done, reported_reps, report_valid,
                    vibrate_pulses, in_set_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/orientation_rep_counter_top.sv
// Rep counter top level: input register, rep logic, result register, tolerance register.
//
// One transaction in, one result out. The block accepts an item in every cycle
// while the output is not stalled. An item waits in the input register, where the
// tolerance compares and flag updates run. Its result is loaded into the result
// register when the result register is free or being emptied, and is presented
// from there to the output channel. Throughput is one item per cycle while the
// output is not stalled, set by that single compare-and-update path, which also
// carries the rep state from one item to the next. A stalled output holds both
// registers and drops input ready once the input register is full. The tolerance
// register resets to 0.3 in Q1.14. The user must write it through i_cfg_we /
// i_cfg_wdata only while no transaction is in flight; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module orientation_rep_counter_top (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_we,
    input  wire [orc_pkg::TOL_W-1:0]  i_cfg_wdata,
    orc_in_if.sink                    i_in,
    orc_out_if.source                 o_out
);

    logic [orc_pkg::TOL_W-1:0] r_tolerance;
    logic                      r_in_valid;
    orc_pkg::t_item            r_item;
    logic                      r_out_valid;
    orc_pkg::t_result          r_out;
    orc_pkg::t_result          w_result;
    logic                      w_advance;
    logic                      w_in_accept;

    // Item moves on when the result register is free or being emptied
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in.valid && i_in.ready;

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= orc_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tolerance <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.opcode <= orc_pkg::t_opcode'(i_in.opcode);
            r_item.quat   <= {i_in.quat_z, i_in.quat_y, i_in.quat_x, i_in.quat_w};
            r_item.pose   <= orc_pkg::t_pose'(i_in.pose_code);
        end
    end

    orc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_item),
        .i_tol     (r_tolerance),
        .o_result  (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.rep_count      = r_out.rep_count;
    assign o_out.rep_done       = r_out.rep_done;
    assign o_out.reported_reps  = r_out.reported_reps;
    assign o_out.report_valid   = r_out.report_valid;
    assign o_out.vibrate_pulses = r_out.vibrate_pulses;
    assign o_out.in_set_flag    = r_out.in_set_flag;

    // Checks
    `ORC_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_advance, r_out_valid, "result lost")
    `ORC_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid, "item dropped")
    `ORC_ASSERT_IMPL(a_report_in_set, i_clk, i_rst_n, r_out_valid && r_out.report_valid, r_out.in_set_flag && r_out.vibrate_pulses == orc_pkg::PULSES_TWO, "report outside set")
    `ORC_ASSERT_IMPL(a_done_count, i_clk, i_rst_n, r_out_valid && r_out.rep_done, r_out.rep_count != '0 && !r_out.report_valid, "rep done with zero count")
    `ORC_ASSERT(a_cfg_idle, i_clk, i_rst_n, i_cfg_we |-> !r_in_valid && !r_out_valid, "tolerance written while busy")

endmodule

`default_nettype wire

// File: rtl/orc_near.sv
// Closeness compare: every component within reference +/- tolerance.
`default_nettype none

module orc_near (
    input  wire orc_pkg::t_quat          i_cur,
    input  wire orc_pkg::t_quat          i_ref,
    input  wire [orc_pkg::TOL_W-1:0]     i_tol,
    output logic                         o_near
);

    logic signed [17:0] w_tol;
    logic [3:0]         w_ok;

    assign w_tol = signed'({3'b000, i_tol});

    // Per-component signed difference against the band, bounds inclusive
    always_comb begin
        logic signed [17:0] diff;
        for (int k = 0; k < 4; k++) begin
            diff = signed'({{2{i_cur[k][15]}}, i_cur[k]})
                 - signed'({{2{i_ref[k][15]}}, i_ref[k]});
            w_ok[k] = (diff <= w_tol) && (diff >= -w_tol);
        end
    end

    assign o_near = &w_ok;

endmodule

`default_nettype wire

// File: rtl/orc_core.sv
// Rep state: references, set and rep flags, counter, and per-item result logic.
`default_nettype none

module orc_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_advance,
    input  wire orc_pkg::t_item         i_item,
    input  wire [orc_pkg::TOL_W-1:0]    i_tol,
    output orc_pkg::t_result            o_result
);

    orc_pkg::t_quat              r_last, n_last;
    orc_pkg::t_quat              r_start, n_start;
    orc_pkg::t_quat              r_end, n_end;
    logic                        r_start_cap, n_start_cap;
    logic                        r_end_cap, n_end_cap;
    logic                        r_set, n_set;
    logic                        r_reached_start, n_reached_start;
    logic                        r_reached_end, n_reached_end;
    logic [orc_pkg::COUNT_W-1:0] r_count, n_count;

    logic w_near_start;
    logic w_near_end;

    orc_near u_near_start (
        .i_cur  (i_item.quat),
        .i_ref  (r_start),
        .i_tol  (i_tol),
        .o_near (w_near_start)
    );

    orc_near u_near_end (
        .i_cur  (i_item.quat),
        .i_ref  (r_end),
        .i_tol  (i_tol),
        .o_near (w_near_end)
    );

    // Next state and result for the item in the input register
    always_comb begin
        n_last          = r_last;
        n_start         = r_start;
        n_end           = r_end;
        n_start_cap     = r_start_cap;
        n_end_cap       = r_end_cap;
        n_set           = r_set;
        n_reached_start = r_reached_start;
        n_reached_end   = r_reached_end;
        n_count         = r_count;
        o_result        = '0;

        if (i_item.opcode == orc_pkg::OP_SAMPLE) begin
            n_last = i_item.quat;
            if (r_set) begin
                if (w_near_start) begin
                    if (!r_reached_start) begin
                        n_reached_start = 1'b1;
                    end else if (r_reached_end) begin
                        if (r_count != orc_pkg::COUNT_MAX) begin
                            n_count = r_count + 16'd1;
                        end
                        n_reached_start    = 1'b0;
                        n_reached_end      = 1'b0;
                        o_result.rep_done  = 1'b1;
                    end
                end else if (w_near_end && r_reached_start) begin
                    n_reached_end = 1'b1;
                end
            end
        end else begin
            case (i_item.pose)
                orc_pkg::POSE_THUMB_PINKY: begin
                    if (!r_start_cap) begin
                        n_start_cap = 1'b1;
                        n_start     = r_last;
                    end else if (!r_end_cap) begin
                        n_end_cap = 1'b1;
                        n_end     = r_last;
                    end
                end
                orc_pkg::POSE_SPREAD: begin
                    if (!r_set) begin
                        n_set                   = 1'b1;
                        o_result.vibrate_pulses = orc_pkg::PULSES_ONE;
                    end else begin
                        o_result.vibrate_pulses = orc_pkg::PULSES_TWO;
                        o_result.reported_reps  = r_count;
                        o_result.report_valid   = 1'b1;
                        n_count                 = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.rep_count   = n_count;
        o_result.in_set_flag = n_set;
    end

    // State registers, updated as each item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last          <= orc_pkg::QUAT_IDENTITY;
            r_start         <= orc_pkg::QUAT_IDENTITY;
            r_end           <= orc_pkg::QUAT_IDENTITY;
            r_start_cap     <= 1'b0;
            r_end_cap       <= 1'b0;
            r_set           <= 1'b0;
            r_reached_start <= 1'b0;
            r_reached_end   <= 1'b0;
            r_count         <= '0;
        end else if (i_advance) begin
            r_last          <= n_last;
            r_start         <= n_start;
            r_end           <= n_end;
            r_start_cap     <= n_start_cap;
            r_end_cap       <= n_end_cap;
            r_set           <= n_set;
            r_reached_start <= n_reached_start;
            r_reached_end   <= n_reached_end;
            r_count         <= n_count;
        end
    end

endmodule

`default_nettype wire
